// ----- hw/rtl/bfga_pkg.sv -----
// Package of shared types and constants for the best-fit gap allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfga_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = 4;
	localparam int BLK_W = 64;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Register reset value and item command codes.
	localparam logic [BLK_W-1:0] FIRST_USABLE_RESET = 64'd34;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// Input item fields.
	typedef struct packed {
		logic cmd;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0] entry_start;
		logic [BLK_W-1:0] entry_blocks;
		logic [BLK_W-1:0] alloc_blocks;
	} in_item_t;

	// Result item fields.
	typedef struct packed {
		logic [BLK_W-1:0] gap_start;
		logic [BLK_W-1:0] gap_blocks;
		logic fits;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic rank_step;
		logic build_order;
		logic scan_read;
		logic scan_update;
		logic finish;
	} bfga_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_request;
		logic rank_last;
		logic scan_last;
		logic out_busy;
	} bfga_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bfga_ctrl.sv -----
// Controller state machine that sequences ranking, ordering and gap scanning.
`timescale 1ns / 1ps
`default_nettype none
module bfga_ctrl
	import bfga_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire bfga_status_t status,
	output bfga_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RANK = 6'b000010,
		ST_ORDER = 6'b000100,
		ST_READ = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				if (accept && status.in_is_request) begin
					state_d = ST_RANK;
				end
			end
			ST_RANK: begin
				cmd.rank_step = 1'b1;
				if (status.rank_last) begin
					state_d = ST_ORDER;
				end
			end
			ST_ORDER: begin
				cmd.build_order = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.scan_read = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.scan_update = 1'b1;
				state_d = status.scan_last ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/bfga_datapath.sv -----
// Datapath: partition table, ranking lanes, sorted order and gap scan registers.
`timescale 1ns / 1ps
`default_nettype none
module bfga_datapath
	import bfga_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [BLK_W-1:0] cfg_wr_data,
	input wire in_item_t in_item,
	output out_item_t out_item,
	output logic out_valid,
	input wire logic out_ready,
	input wire bfga_cmd_t cmd,
	output bfga_status_t status
);

	logic [BLK_W-1:0] start_tab_q [TABLE_ENTRIES];
	logic [BLK_W-1:0] len_tab_q [TABLE_ENTRIES];
	logic [BLK_W-1:0] first_usable_q;
	in_item_t item_q;
	logic [IDX_W-1:0] rank_q [TABLE_ENTRIES];
	logic [IDX_W-1:0] ord_q [TABLE_ENTRIES];
	logic [IDX_W-1:0] row_q;
	logic [CNT_W-1:0] zero_cnt_q;
	logic [IDX_W-1:0] k_q;
	logic first_q;
	logic [BLK_W-1:0] prev_end_q;
	logic [BLK_W-1:0] best_start_q;
	logic [BLK_W-1:0] best_blocks_q;
	logic [BLK_W-1:0] start_s1;
	logic [BLK_W-1:0] end_s1;
	logic [BLK_W-1:0] gap_s1;
	out_item_t out_q;
	logic out_valid_q;

	logic [IDX_W-1:0] rd_idx;
	logic [BLK_W-1:0] rd_start;
	logic [BLK_W-1:0] rd_len;
	logic [IDX_W-1:0] k_first;
	logic load_wr;
	logic fin_wr;
	logic [IDX_W-1:0] wr_idx;
	logic [BLK_W-1:0] wr_start;
	logic [BLK_W-1:0] wr_len;
	logic take_gap;

	// One table read port, shared by the ranking rows and the gap scan.
	assign rd_idx = cmd.rank_step ? row_q : ord_q[k_q];
	assign rd_start = start_tab_q[rd_idx];
	assign rd_len = len_tab_q[rd_idx];

	// The skip over undefined entries stops at the last sorted entry.
	assign k_first = (zero_cnt_q > CNT_W'(TABLE_ENTRIES - 1)) ? LAST_IDX
		: zero_cnt_q[IDX_W-1:0];

	// Table write: a load item at once, a request once its gap is chosen.
	assign load_wr = cmd.capture && (in_item.cmd == CMD_LOAD)
		&& (32'(in_item.slot) < TABLE_ENTRIES);
	assign fin_wr = cmd.finish && (32'(item_q.slot) < TABLE_ENTRIES);
	assign wr_idx = load_wr ? IDX_W'(in_item.slot) : IDX_W'(item_q.slot);
	assign wr_start = load_wr ? in_item.entry_start : best_start_q;
	assign wr_len = load_wr ? in_item.entry_blocks : item_q.alloc_blocks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				start_tab_q[i] <= '0;
				len_tab_q[i] <= '0;
			end
		end else if (load_wr || fin_wr) begin
			start_tab_q[wr_idx] <= wr_start;
			len_tab_q[wr_idx] <= wr_len;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_usable_q <= FIRST_USABLE_RESET;
		end else if (cfg_wr_en) begin
			first_usable_q <= cfg_wr_data;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
	end

	// Ranking: one row a cycle, each lane counts entries ordered before it.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q <= '0;
			zero_cnt_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.rank_step) begin
			row_q <= row_q + 1'b1;
			zero_cnt_q <= zero_cnt_q + CNT_W'(rd_start == '0);
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if ((rd_start < start_tab_q[i])
						|| ((rd_start == start_tab_q[i]) && (row_q < IDX_W'(i)))) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	// Sorted order is the inverse of the rank permutation.
	always_ff @(posedge clk) begin
		if (cmd.build_order) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				ord_q[rank_q[i]] <= IDX_W'(i);
			end
		end
	end

	// Scan read stage: fetch the next sorted entry, its end and its gap.
	always_ff @(posedge clk) begin
		if (cmd.scan_read) begin
			start_s1 <= rd_start;
			end_s1 <= rd_start + rd_len;
			gap_s1 <= rd_start - prev_end_q;
		end
	end

	// Best fit: the gap holds the request and beats any kept gap that fits.
	assign take_gap = (item_q.alloc_blocks <= gap_s1)
		&& ((gap_s1 < best_blocks_q) || (best_blocks_q < item_q.alloc_blocks));

	// Scan update stage.
	always_ff @(posedge clk) begin
		if (cmd.build_order) begin
			k_q <= k_first;
			first_q <= 1'b1;
		end else if (cmd.scan_update) begin
			k_q <= k_q + 1'b1;
			first_q <= 1'b0;
			prev_end_q <= end_s1;
			if (first_q) begin
				best_start_q <= first_usable_q;
				best_blocks_q <= start_s1 - first_usable_q;
			end else if (take_gap) begin
				best_start_q <= prev_end_q;
				best_blocks_q <= gap_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.gap_start <= best_start_q;
			out_q.gap_blocks <= best_blocks_q;
			out_q.fits <= (best_blocks_q >= item_q.alloc_blocks);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_item = out_q;
	assign out_valid = out_valid_q;

	// Status back to the controller.
	assign status.in_is_request = (in_item.cmd == CMD_REQUEST);
	assign status.rank_last = (row_q == LAST_IDX);
	assign status.scan_last = (k_q == LAST_IDX);
	assign status.out_busy = out_valid_q && !out_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/best_fit_gap_allocator_top.sv -----
// Top level of the best-fit gap allocator: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// A load item writes one partition table entry and gives no result. A
// request item ranks the sixteen entries by start (one row of sixteen
// comparisons a cycle), builds the sorted order, scans the gaps with a read
// step and an update step per sorted entry from the first defined one, then
// writes the target slot and loads the result register; the next item is
// taken in the cycle after that. The single table read port and the scan's
// read and update steps set the pace. A load item is taken while a result
// still waits in the output register; a request holds in its final step
// until that register is free. The table is zero and first_usable_block is
// 34 after reset; write first_usable_block only while the block is idle.
module best_fit_gap_allocator_top
	import bfga_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [BLK_W-1:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_item
);

	bfga_cmd_t cmd;
	bfga_status_t status;

	bfga_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	bfga_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_item(in_item),
		.out_item(out_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.status(status)
	);

endmodule
`default_nettype wire
